@@ rtl/bfsc_pkg.sv @@
// Shared types, constants and fixed-point helpers of the Burgers stencil cost unit.
package bfsc_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int SW = 50;
	localparam int MW = 48;
	localparam logic [62:0] COST_MAX = {63{1'b1}};
	localparam logic signed [31:0] Q_HALF = 32'sd32768;

	localparam logic [2:0] REG_GRID_POINTS = 3'd0;
	localparam logic [2:0] REG_TIME_STEPS = 3'd1;
	localparam logic [2:0] REG_COURANT = 3'd2;
	localparam logic [2:0] REG_DIFFUSION = 3'd3;
	localparam logic [2:0] REG_LEAPFROG = 3'd4;

	typedef struct packed {
		logic command;
		logic signed [31:0] value;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] model_value;
		logic [62:0] cost;
		logic last;
	} out_beat_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_LATCH, OP_RD_CUR, OP_CAP_CUR,
		OP_RD_L, OP_RD_C, OP_RD_R, OP_DIFF,
		OP_FT1, OP_FT2, OP_FT3, OP_FT4, OP_FT5, OP_FT6,
		OP_LF1, OP_LF2, OP_LF3, OP_LF4, OP_LF5,
		OP_SQ, OP_ACC, OP_DONE
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD_CUR, ST_CAP_CUR, ST_RD_L, ST_RD_C, ST_RD_R, ST_DIFF,
		ST_FT1, ST_FT2, ST_FT3, ST_FT4, ST_FT5, ST_FT6,
		ST_LF1, ST_LF2, ST_LF3, ST_LF4, ST_LF5,
		ST_SQ, ST_ACC, ST_DONE
	} state_t;

	typedef struct packed {
		logic loaded;
		logic boundary;
		logic lvl0;
		logic lvl1;
		logic out_free;
	} dp_status_t;

	function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] x);
		if (x > $signed({{(SW-32){1'b0}}, 32'h7fffffff})) begin
			return 32'sh7fffffff;
		end else if (x < $signed({{(SW-32){1'b1}}, 32'h80000000})) begin
			return 32'sh80000000;
		end else begin
			return x[31:0];
		end
	endfunction

	function automatic logic [1:0] bank_inc(input logic [1:0] b);
		return (b == 2'd2) ? 2'd0 : b + 2'd1;
	endfunction

endpackage

@@ rtl/bfsc_ram.sv @@
// Single-port-write, registered-read row store of one bank.
module bfsc_ram
	import bfsc_pkg::*;
(
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0] rdata
);

	logic [31:0] mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/bfsc_ctrl.sv @@
// Sequencer that steps the datapath through one grid point per observation.
module bfsc_ctrl
	import bfsc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_command,
	output logic in_ready,
	input  dp_status_t status,
	output op_t op
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op = OP_NOP;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!in_command) begin
						op = OP_LOAD;
					end else if (status.loaded) begin
						op = OP_LATCH;
						if (status.boundary) state_d = ST_SQ;
						else if (status.lvl0) state_d = ST_RD_CUR;
						else state_d = ST_RD_L;
					end
				end
			end
			ST_RD_CUR: begin op = OP_RD_CUR; state_d = ST_CAP_CUR; end
			ST_CAP_CUR: begin op = OP_CAP_CUR; state_d = ST_SQ; end
			ST_RD_L: begin op = OP_RD_L; state_d = ST_RD_C; end
			ST_RD_C: begin op = OP_RD_C; state_d = ST_RD_R; end
			ST_RD_R: begin op = OP_RD_R; state_d = ST_DIFF; end
			ST_DIFF: begin
				op = OP_DIFF;
				state_d = status.lvl1 ? ST_FT1 : ST_LF1;
			end
			ST_FT1: begin op = OP_FT1; state_d = ST_FT2; end
			ST_FT2: begin op = OP_FT2; state_d = ST_FT3; end
			ST_FT3: begin op = OP_FT3; state_d = ST_FT4; end
			ST_FT4: begin op = OP_FT4; state_d = ST_FT5; end
			ST_FT5: begin op = OP_FT5; state_d = ST_FT6; end
			ST_FT6: begin op = OP_FT6; state_d = ST_SQ; end
			ST_LF1: begin op = OP_LF1; state_d = ST_LF2; end
			ST_LF2: begin op = OP_LF2; state_d = ST_LF3; end
			ST_LF3: begin op = OP_LF3; state_d = ST_LF4; end
			ST_LF4: begin op = OP_LF4; state_d = ST_LF5; end
			ST_LF5: begin op = OP_LF5; state_d = ST_SQ; end
			ST_SQ: begin op = OP_SQ; state_d = ST_ACC; end
			ST_ACC: begin op = OP_ACC; state_d = ST_DONE; end
			ST_DONE: begin
				if (status.out_free) begin
					op = OP_DONE;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ rtl/bfsc_dp.sv @@
// Datapath: configuration, row banks, shared multiplier, cost sum and output register.
module bfsc_dp
	import bfsc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  in_beat_t in_data,
	input  op_t op,
	output dp_status_t status,
	output logic out_valid,
	input  logic out_ready,
	output out_beat_t out_data
);

	logic [10:0] grid_points_q;
	logic [15:0] time_steps_q;
	logic signed [31:0] courant_q, diffusion_q, leapfrog_q;
	logic [10:0] load_count_q;
	logic [AW-1:0] space_index_q;
	logic [15:0] time_index_q;
	logic [62:0] cost_q;
	logic [1:0] rot_q;

	logic signed [31:0] obs_q, v_q, pl_q, pc_q, o_q, dlr_q, lap_q, lfs_q;
	logic signed [MW-1:0] mul_q, t1_q, t2_q;
	logic [63:0] sq_q;
	logic out_valid_q;
	out_beat_t out_q;

	logic [10:0] nx;
	logic [15:0] nt;
	logic end_row, last_pt;
	logic [1:0] prev_bank, old_bank;
	logic [AW-1:0] prev_addr;
	logic [31:0] rdata [3];
	logic signed [31:0] rd_cur, rd_prev, rd_old;
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod, rnd;
	logic signed [32:0] diff;
	logic [31:0] mag;
	logic [63:0] term, sum;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic signed [31:0] wr_data;
	logic [10:0] i_ext;

	always_comb begin
		nx = grid_points_q;
		if (grid_points_q < 11'd3) nx = 11'd3;
		if (grid_points_q > 11'(MAX_POINTS)) nx = 11'(MAX_POINTS);
		nt = (time_steps_q < 16'd2) ? 16'd2 : time_steps_q;
		i_ext = {{(11-AW){1'b0}}, space_index_q};
		end_row = i_ext >= nx - 11'd1;
		last_pt = end_row && (time_index_q >= nt - 16'd1);
	end

	assign status.loaded = load_count_q >= nx;
	assign status.boundary = (space_index_q == '0) || end_row;
	assign status.lvl0 = time_index_q == 16'd0;
	assign status.lvl1 = time_index_q == 16'd1;
	assign status.out_free = !out_valid_q || out_ready;

	assign prev_bank = bank_inc(rot_q);
	assign old_bank = bank_inc(prev_bank);

	always_comb begin
		case (op)
			OP_RD_L: prev_addr = space_index_q - AW'(1);
			OP_RD_R: prev_addr = space_index_q + AW'(1);
			default: prev_addr = space_index_q;
		endcase
		wr_en = 1'b0;
		wr_addr = space_index_q;
		wr_data = v_q;
		if (op == OP_LOAD && !status.loaded) begin
			wr_en = 1'b1;
			wr_addr = load_count_q[AW-1:0];
			wr_data = in_data.value;
		end else if (op == OP_SQ) begin
			wr_en = 1'b1;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_bank
		bfsc_ram u_ram (
			.clk(clk),
			.we(wr_en && (rot_q == 2'(k))),
			.waddr(wr_addr),
			.wdata(wr_data),
			.raddr((prev_bank == 2'(k)) ? prev_addr : space_index_q),
			.rdata(rdata[k])
		);
	end

	assign rd_cur = rdata[rot_q];
	assign rd_prev = rdata[prev_bank];
	assign rd_old = rdata[old_bank];

	always_comb begin
		diff = {v_q[31], v_q} - {obs_q[31], obs_q};
		mag = diff[32] ? 32'(-diff) : diff[31:0];
		ma = '0;
		mb = '0;
		case (op)
			OP_FT1: begin ma = 33'(Q_HALF); mb = 33'(courant_q); end
			OP_FT2: begin ma = 33'(sat32(SW'(mul_q))); mb = 33'(pc_q); end
			OP_FT3: begin ma = 33'(sat32(SW'(mul_q))); mb = 33'(dlr_q); end
			OP_FT4: begin ma = 33'(Q_HALF); mb = 33'(diffusion_q); end
			OP_FT5: begin ma = 33'(sat32(SW'(mul_q))); mb = 33'(lap_q); end
			OP_LF1: begin ma = 33'(diffusion_q); mb = 33'(lfs_q); end
			OP_LF2: begin ma = 33'(courant_q); mb = 33'(pc_q); end
			OP_LF3: begin ma = 33'(sat32(SW'(mul_q))); mb = 33'(dlr_q); end
			OP_LF4: begin ma = 33'(leapfrog_q); mb = 33'(sat32(SW'(t1_q))); end
			OP_SQ: begin ma = {1'b0, mag}; mb = {1'b0, mag}; end
			default: begin ma = '0; mb = '0; end
		endcase
		prod = ma * mb;
		rnd = prod + 66'sd32768;
		term = {1'b0, sq_q[63:1]} + {63'd0, sq_q[0]};
		sum = {1'b0, cost_q} + term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_points_q <= 11'd64;
			time_steps_q <= 16'd64;
			courant_q <= '0;
			diffusion_q <= '0;
			leapfrog_q <= 32'sd65536;
			load_count_q <= '0;
			space_index_q <= '0;
			time_index_q <= '0;
			cost_q <= '0;
			rot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_POINTS: grid_points_q <= cfg_data[10:0];
					REG_TIME_STEPS: time_steps_q <= cfg_data[15:0];
					REG_COURANT: courant_q <= cfg_data;
					REG_DIFFUSION: diffusion_q <= cfg_data;
					REG_LEAPFROG: leapfrog_q <= cfg_data;
					default: ;
				endcase
			end
			if (op == OP_LOAD && !status.loaded) begin
				load_count_q <= load_count_q + 11'd1;
			end
			if (op == OP_ACC) begin
				cost_q <= (sum > {1'b0, COST_MAX}) ? COST_MAX : sum[62:0];
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (op == OP_DONE) begin
				out_valid_q <= 1'b1;
				if (end_row) begin
					rot_q <= (rot_q == 2'd0) ? 2'd2 : rot_q - 2'd1;
					space_index_q <= '0;
					if (last_pt) begin
						load_count_q <= '0;
						time_index_q <= '0;
						cost_q <= '0;
					end else begin
						time_index_q <= time_index_q + 16'd1;
					end
				end else begin
					space_index_q <= space_index_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LATCH: begin obs_q <= in_data.value; v_q <= '0; end
			OP_CAP_CUR: v_q <= rd_cur;
			OP_RD_C: begin pl_q <= rd_prev; o_q <= rd_old; end
			OP_RD_R: pc_q <= rd_prev;
			OP_DIFF: begin
				dlr_q <= sat32(SW'(rd_prev) - SW'(pl_q));
				lap_q <= sat32(SW'(rd_prev) - (SW'(pc_q) <<< 1) + SW'(pl_q));
				lfs_q <= sat32(SW'(rd_prev) - SW'(o_q) + SW'(pl_q));
			end
			OP_FT4: t1_q <= mul_q;
			OP_FT6: v_q <= sat32(SW'(pc_q) - SW'(t1_q) + SW'(mul_q));
			OP_LF2: t1_q <= MW'(o_q) + mul_q;
			OP_LF4: t2_q <= mul_q;
			OP_LF5: v_q <= sat32(SW'(mul_q) - SW'(t2_q));
			OP_DONE: begin
				out_q.model_value <= v_q;
				out_q.cost <= cost_q;
				out_q.last <= last_pt;
			end
			default: ;
		endcase
		case (op)
			OP_FT1, OP_FT2, OP_FT3, OP_FT4, OP_FT5,
			OP_LF1, OP_LF2, OP_LF3, OP_LF4, OP_SQ: begin
				mul_q <= rnd[MW+15:16];
				sq_q <= prod[63:0];
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

@@ rtl/burgers_forward_stencil_cost_unit.sv @@
// Top level of the one-dimensional Burgers forward model with misfit cost.
// Load beats fill the initial row; one observation beat then yields one result beat. At a
// boundary point an observation goes straight to the cost square and saturating add; on the
// first level a read of the current row comes first, on later levels three reads of the
// previous row through one bank port and a chain of products through the single shared multiplier
// (forward-time on the second level, leapfrog after it). A waiting result holds an observation
// only in its done state. The three row banks rotate roles at each row end, so no copy is made.
module burgers_forward_stencil_cost_unit
	import bfsc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  in_beat_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_beat_t out_data
);

	op_t op;
	dp_status_t status;

	bfsc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_command(in_data.command),
		.in_ready(in_ready),
		.status(status),
		.op(op)
	);

	bfsc_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.op(op),
		.status(status),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule
